### hw/rtl/assert_macros.svh
// Assertion macros for the sparse row store RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge outside reset
`define SRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every rising clk edge, reset included
`define SRS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/srs_pkg.sv
// Package for the sparse row store: item structs, opcodes, status codes
// and configuration register indexes. No dependencies.
`default_nettype none
package srs_pkg;

  localparam logic [1:0] OP_INSERT   = 2'd0;
  localparam logic [1:0] OP_LOOKUP   = 2'd1;
  localparam logic [1:0] OP_READ_IDX = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_SLOT  = 2'd3;

  localparam logic CFG_ROWS_IN_USE = 1'b0;
  localparam logic CFG_COLS_IN_USE = 1'b1;

  localparam int CFG_DATA_BITS = 9;
  localparam logic [4:0] ROWS_IN_USE_RST = 5'd16;
  localparam logic [8:0] COLS_IN_USE_RST = 9'd256;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         row;
    logic [7:0]         column;
    logic [2:0]         slot;
    logic signed [31:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [7:0]         read_column;
    logic               found;
    logic [1:0]         status;
  } out_item_t;

endpackage
`default_nettype wire

### hw/rtl/srs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module srs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/sparse_row_sorted_store.sv
// Top level of the sparse row store: one row word per RAM entry, read,
// modified and written back. Depends on srs_pkg, srs_ram, assert_macros.svh.
//
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_ready    srs_pkg::in_item_t
//  out_      output     out_valid/out_ready  srs_pkg::out_item_t
//  cfg_      input      cfg_we               cfg_index, cfg_wdata
//
// For each item, the row word is read from the row RAM on
// acceptance, then compared, updated and written back in the next cycle.
// The RAM's registered read and single write port mean one item is handled at a time.
// Reset clears the row valid bits (row counts read as zero) and restores config.
// A result that finds another waiting on out_ready goes to a spare register;
// while the spare is full, in_ready stays low until the first is taken.
`default_nettype none
`include "assert_macros.svh"
module sparse_row_sorted_store #(
  parameter int ROWS         = 16,
  parameter int COLS         = 256,
  parameter int ROW_CAPACITY = 8,
  parameter int VALUE_BITS   = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire srs_pkg::in_item_t                  in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output srs_pkg::out_item_t                      out_item,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [srs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

  localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CB    = $clog2(COLS);
  localparam int SB    = (ROW_CAPACITY > 1) ? $clog2(ROW_CAPACITY) : 1;
  localparam int CNTB  = $clog2(ROW_CAPACITY + 1);
  localparam int EW    = CB + VALUE_BITS;
  localparam int WORDW = ROW_CAPACITY * EW + CNTB;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state_r, state_nxt;
  logic [4:0]          rows_in_use_r;
  logic [8:0]          cols_in_use_r;
  logic [ROWS-1:0]     row_vld_r, row_vld_nxt;
  srs_pkg::in_item_t   item_r;
  logic                out_valid_r, out_valid_nxt;
  srs_pkg::out_item_t  out_item_r, out_item_nxt;
  logic                spare_valid_r, spare_valid_nxt;
  srs_pkg::out_item_t  spare_item_r, spare_item_nxt;
  logic                exec_done;
  srs_pkg::out_item_t  res_item;

  logic                in_acc;
  logic [15:0]         in_row_ext, cur_row_ext;
  logic [RB-1:0]       raddr, cur_addr;
  logic [WORDW-1:0]    rd_word, wr_word;
  logic                ram_we;

  logic [CB-1:0]          cols_q [ROW_CAPACITY];
  logic [VALUE_BITS-1:0]  vals_q [ROW_CAPACITY];
  logic [CB-1:0]          cols_w [ROW_CAPACITY];
  logic [VALUE_BITS-1:0]  vals_w [ROW_CAPACITY];
  logic [ROW_CAPACITY-1:0] lt, eq;
  logic [CNTB-1:0]        cnt, cnt_w;
  logic                   row_ok, col_ok, hit, full;
  logic [VALUE_BITS-1:0]  hit_val, new_val;
  logic [CB-1:0]          new_col;
  logic [7:0]             slot_ext;
  logic [SB-1:0]          slot_sel;
  logic                   slot_ok;

  assign in_acc     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE) && !spare_valid_r;
  assign out_valid  = out_valid_r;
  assign out_item   = out_item_r;
  assign in_row_ext = 16'(in_item.row);
  assign raddr      = in_row_ext[RB-1:0];
  assign cur_row_ext = 16'(item_r.row);
  assign cur_addr    = cur_row_ext[RB-1:0];

  srs_ram #(
    .WIDTH(WORDW),
    .DEPTH(ROWS)
  ) u_row_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_addr),
    .wdata(wr_word),
    .raddr(raddr),
    .rdata(rd_word)
  );

  assign row_ok = ({1'b0, item_r.row} < rows_in_use_r) && (32'(item_r.row) < ROWS);
  assign col_ok = ({1'b0, item_r.column} < cols_in_use_r) && (32'(item_r.column) < COLS);
  assign cnt    = (row_ok && row_vld_r[cur_addr]) ? rd_word[ROW_CAPACITY*EW +: CNTB] : '0;
  assign full   = cnt >= CNTB'(ROW_CAPACITY);
  assign new_col = CB'(item_r.column);
  assign new_val = VALUE_BITS'({32'b0, item_r.entry_value});
  assign slot_ext = 8'(item_r.slot);
  assign slot_sel = slot_ext[SB-1:0];
  assign slot_ok  = (slot_ext < 8'(cnt)) && (slot_ext < 8'(ROW_CAPACITY));

  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      cols_q[i] = rd_word[i*EW +: CB];
      vals_q[i] = rd_word[i*EW+CB +: VALUE_BITS];
      lt[i] = (CNTB'(i) < cnt) && (16'(cols_q[i]) < 16'(item_r.column));
      eq[i] = (CNTB'(i) < cnt) && (16'(cols_q[i]) == 16'(item_r.column));
      hit     = hit | eq[i];
      hit_val = hit_val | (eq[i] ? vals_q[i] : '0);
    end
  end

  // overwrite in place on a hit, else shift up past the sorted position
  always_comb begin
    cnt_w = hit ? cnt : cnt + CNTB'(1);
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      if (hit) begin
        cols_w[i] = cols_q[i];
        vals_w[i] = eq[i] ? new_val : vals_q[i];
      end else if (lt[i]) begin
        cols_w[i] = cols_q[i];
        vals_w[i] = vals_q[i];
      end else if (i == 0 || lt[(i > 0) ? i-1 : 0]) begin
        cols_w[i] = new_col;
        vals_w[i] = new_val;
      end else begin
        cols_w[i] = cols_q[(i > 0) ? i-1 : 0];
        vals_w[i] = vals_q[(i > 0) ? i-1 : 0];
      end
    end
    wr_word = '0;
    for (int i = 0; i < ROW_CAPACITY; i++) begin
      wr_word[i*EW +: CB]            = cols_w[i];
      wr_word[i*EW+CB +: VALUE_BITS] = vals_w[i];
    end
    wr_word[ROW_CAPACITY*EW +: CNTB] = cnt_w;
  end

  always_comb begin
    state_nxt   = state_r;
    exec_done   = 1'b0;
    res_item    = '0;
    row_vld_nxt = row_vld_r;
    ram_we      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        exec_done = 1'b1;
        if (item_r.opcode == srs_pkg::OP_READ_IDX) begin
          if (!row_ok) begin
            res_item.status = srs_pkg::ST_RANGE;
          end else if (!slot_ok) begin
            res_item.status = srs_pkg::ST_SLOT;
          end else begin
            res_item.read_column = 8'(cols_q[slot_sel]);
            res_item.status      = srs_pkg::ST_OK;
          end
        end else if (item_r.opcode == srs_pkg::OP_UNUSED || !row_ok || !col_ok) begin
          res_item.status = srs_pkg::ST_RANGE;
        end else if (item_r.opcode == srs_pkg::OP_LOOKUP) begin
          res_item.read_value = 32'(hit_val);
          res_item.found      = hit;
          res_item.status     = srs_pkg::ST_OK;
        end else if (!hit && full) begin
          res_item.status = srs_pkg::ST_FULL;
        end else begin
          ram_we                = 1'b1;
          row_vld_nxt[cur_addr] = 1'b1;
          res_item.status       = srs_pkg::ST_OK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // advance the spare result on a take, park a new result behind a waiting one
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_item_nxt    = out_item_r;
    spare_valid_nxt = spare_valid_r;
    spare_item_nxt  = spare_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt   = spare_valid_r;
      out_item_nxt    = spare_item_r;
      spare_valid_nxt = 1'b0;
    end
    if (exec_done) begin
      if (out_valid_nxt) begin
        spare_valid_nxt = 1'b1;
        spare_item_nxt  = res_item;
      end else begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = res_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      spare_valid_r <= 1'b0;
      row_vld_r     <= '0;
      rows_in_use_r <= srs_pkg::ROWS_IN_USE_RST;
      cols_in_use_r <= srs_pkg::COLS_IN_USE_RST;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      spare_valid_r <= spare_valid_nxt;
      row_vld_r     <= row_vld_nxt;
      if (cfg_we && cfg_index == srs_pkg::CFG_ROWS_IN_USE) begin
        rows_in_use_r <= cfg_wdata[4:0];
      end
      if (cfg_we && cfg_index == srs_pkg::CFG_COLS_IN_USE) begin
        cols_in_use_r <= cfg_wdata[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item;
    end
    out_item_r   <= out_item_nxt;
    spare_item_r <= spare_item_nxt;
  end

  `SRS_ASSERT(a_exec_slot_free, (state_r == ST_EXEC) |-> !spare_valid_r, "spare slot busy in exec")
  `SRS_ASSERT(a_acc_to_exec, in_acc |=> (state_r == ST_EXEC), "accepted item did not execute")
  `SRS_ASSERT(a_exec_result, (state_r == ST_EXEC) |=> (out_valid_r && state_r == ST_IDLE), "exec gave no result")
  `SRS_ASSERT_ALWAYS(a_we_in_exec, ram_we |-> (state_r == ST_EXEC), "row write outside exec")

endmodule
`default_nettype wire

### tb/tb_sparse_row_sorted_store.sv
// Testbench for sparse_row_sorted_store: per-row sorted entry store with insert,
// lookup and read by slot, checked item by item against an in-bench predictor.
// Depends on srs_pkg and the RTL of the block only.
`timescale 1ns / 100ps
module tb_sparse_row_sorted_store;

  localparam int NUM_ROWS   = 16;
  localparam int ROW_CAP    = 8;
  localparam int HOT_COLS   = 12;
  localparam int PHASE_OPS  = 265;
  localparam int CYCLE_CAP  = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  srs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  srs_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic cfg_index = srs_pkg::CFG_ROWS_IN_USE;
  logic [srs_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  sparse_row_sorted_store dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  srs_pkg::in_item_t queued_ops[$];
  srs_pkg::out_item_t pending_results[$];
  logic [7:0] row_cols[NUM_ROWS][ROW_CAP];
  logic signed [31:0] row_vals[NUM_ROWS][ROW_CAP];
  int row_fill[NUM_ROWS];
  int rows_lim = 16;
  int cols_lim = 256;
  logic [7:0] hot_col[HOT_COLS];
  logic [3:0] last_row = '0;
  logic steady = 1'b0;
  int errors = 0;
  int cycles = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic srs_pkg::out_item_t store_apply(srs_pkg::in_item_t it);
    srs_pkg::out_item_t res;
    int n, p, k;
    bit row_ok, col_ok;
    res = '0;
    row_ok = it.row < rows_lim;
    col_ok = it.column < cols_lim;
    if (it.opcode == srs_pkg::OP_READ_IDX) begin
      if (!row_ok) res.status = srs_pkg::ST_RANGE;
      else if (it.slot >= row_fill[it.row]) res.status = srs_pkg::ST_SLOT;
      else res.read_column = row_cols[it.row][it.slot];
      return res;
    end
    if (it.opcode == srs_pkg::OP_UNUSED || !row_ok || !col_ok) begin
      res.status = srs_pkg::ST_RANGE;
      return res;
    end
    n = row_fill[it.row];
    p = n;
    for (k = n - 1; k >= 0; k--)
      if (row_cols[it.row][k] >= it.column) p = k;
    if (p < n && row_cols[it.row][p] == it.column) begin
      if (it.opcode == srs_pkg::OP_INSERT) begin
        row_vals[it.row][p] = it.entry_value;
      end else begin
        res.read_value = row_vals[it.row][p];
        res.found = 1'b1;
      end
      return res;
    end
    if (it.opcode == srs_pkg::OP_LOOKUP) return res;
    if (n >= ROW_CAP) begin
      res.status = srs_pkg::ST_FULL;
      return res;
    end
    for (k = n; k > p; k--) begin
      row_cols[it.row][k] = row_cols[it.row][k-1];
      row_vals[it.row][k] = row_vals[it.row][k-1];
    end
    row_cols[it.row][p] = it.column;
    row_vals[it.row][p] = it.entry_value;
    row_fill[it.row] = n + 1;
    return res;
  endfunction

  function automatic srs_pkg::in_item_t random_op();
    srs_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) it.opcode = srs_pkg::OP_INSERT;
    else if (pick < 72) it.opcode = srs_pkg::OP_LOOKUP;
    else if (pick < 96) it.opcode = srs_pkg::OP_READ_IDX;
    else it.opcode = srs_pkg::OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 35) it.row = last_row;
    else if (pick < 85) it.row = 4'($urandom_range(rows_lim - 1));
    else it.row = 4'($urandom_range(NUM_ROWS - 1));
    last_row = it.row;
    pick = $urandom_range(99);
    if (pick < 70) it.column = hot_col[$urandom_range(HOT_COLS - 1)];
    else if (pick < 80) it.column = 8'(cols_lim - 1);
    else if (pick < 88) it.column = (cols_lim > 255) ? 8'd255 : 8'(cols_lim);
    else it.column = 8'($urandom_range(255));
    it.slot = 3'($urandom_range(ROW_CAP - 1));
    pick = $urandom_range(99);
    if (pick < 4) it.entry_value = 32'h8000_0000;
    else if (pick < 8) it.entry_value = 32'h7fff_ffff;
    else if (pick < 10) it.entry_value = '0;
    else it.entry_value = $urandom;
    return it;
  endfunction

  task automatic push_op(logic [1:0] op, logic [3:0] row, logic [7:0] col,
                         logic [2:0] slot, logic [31:0] val);
    srs_pkg::in_item_t it;
    it.opcode = op;
    it.row = row;
    it.column = col;
    it.slot = slot;
    it.entry_value = val;
    queued_ops = {queued_ops, it};
  endtask

  task automatic write_reg(logic idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[srs_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srs_pkg::CFG_ROWS_IN_USE) rows_lim = val;
    else cols_lim = val;
  endtask

  task automatic wait_drained();
    while (queued_ops.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
  endtask

  // driver: predict on each accepted item, then present the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        pending_results = {pending_results, store_apply(in_item)};
      if (!in_valid || in_ready) begin
        if (queued_ops.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
          in_item <= queued_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 9);
  end

  // monitor: compare each taken result with the oldest prediction
  always @(posedge clk) begin
    srs_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none pending", out_item, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.read_value !== want.read_value)
          report_mismatch("read_value", out_item.read_value, want.read_value);
        if (out_item.read_column !== want.read_column)
          report_mismatch("read_column", out_item.read_column, want.read_column);
        if (out_item.found !== want.found)
          report_mismatch("found", out_item.found, want.found);
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int ph, i, h;
    int phase_rows[6] = '{16, 1, 16, 4, 12, 16};
    int phase_cols[6] = '{256, 1, 256, 37, 200, 8};
    for (i = 0; i < NUM_ROWS; i++) row_fill[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty row, extreme columns and values, overwrite, read by slot
    push_op(srs_pkg::OP_READ_IDX, 4'd0, 8'd0, 3'd0, 32'd0);
    push_op(srs_pkg::OP_LOOKUP, 4'd0, 8'd0, 3'd0, 32'd0);
    push_op(srs_pkg::OP_INSERT, 4'd0, 8'd128, 3'd0, 32'h7fff_ffff);
    push_op(srs_pkg::OP_INSERT, 4'd0, 8'd0, 3'd0, 32'h8000_0000);
    push_op(srs_pkg::OP_INSERT, 4'd0, 8'd255, 3'd7, 32'hffff_ffff);
    push_op(srs_pkg::OP_LOOKUP, 4'd0, 8'd255, 3'd0, 32'd0);
    push_op(srs_pkg::OP_LOOKUP, 4'd0, 8'd0, 3'd0, 32'd0);
    push_op(srs_pkg::OP_INSERT, 4'd0, 8'd128, 3'd0, 32'd0);
    push_op(srs_pkg::OP_READ_IDX, 4'd0, 8'd0, 3'd0, 32'd0);
    push_op(srs_pkg::OP_READ_IDX, 4'd0, 8'd0, 3'd1, 32'd0);
    push_op(srs_pkg::OP_READ_IDX, 4'd0, 8'd0, 3'd2, 32'd0);
    push_op(srs_pkg::OP_READ_IDX, 4'd0, 8'd0, 3'd7, 32'd0);
    // fill the last row front-first, then hit it when full
    for (i = 0; i < ROW_CAP; i++)
      push_op(srs_pkg::OP_INSERT, 4'd15, 8'(200 - 20 * i), 3'd0, 32'(i * 32'h1111_1111));
    push_op(srs_pkg::OP_INSERT, 4'd15, 8'd1, 3'd0, 32'd5);
    push_op(srs_pkg::OP_INSERT, 4'd15, 8'd60, 3'd0, 32'h5a5a_5a5a);
    push_op(srs_pkg::OP_READ_IDX, 4'd15, 8'd0, 3'd7, 32'd0);
    push_op(srs_pkg::OP_UNUSED, 4'd3, 8'd3, 3'd3, 32'd3);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      write_reg(srs_pkg::CFG_ROWS_IN_USE, phase_rows[ph]);
      write_reg(srs_pkg::CFG_COLS_IN_USE, phase_cols[ph]);
      steady <= (ph == 2);
      for (h = 0; h < HOT_COLS; h++)
        hot_col[h] = 8'($urandom_range(((cols_lim > 256) ? 256 : cols_lim) - 1));
      for (i = 0; i < PHASE_OPS; i++)
        queued_ops = {queued_ops, random_op()};
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
